// ===== rtl/srtl_pkg.sv =====
package srtl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Operations that the table engine carries out.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_BELOW_BASE = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_INSERTED   = 3'd4,
        ST_DROPPED    = 3'd5,
        ST_FULL       = 3'd6,
        ST_CLEARED    = 3'd7
    } t_status;

    // One table entry as it is stored.
    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] stop_addr;
        logic [31:0] unwind_addr;
    } t_entry;

    // One result item.
    typedef struct packed {
        t_status            status;
        t_entry             match;
        logic [CNT_W-1:0]   count;
    } t_result;

    // Command from the front end to the table engine.
    typedef struct packed {
        logic        start;
        t_op         op;
        logic [31:0] key;
        t_entry      entry;
    } t_tbl_cmd;

    // Response from the table engine; count is always the live entry count.
    typedef struct packed {
        logic    done;
        t_result res;
    } t_tbl_rsp;

endpackage

// ===== rtl/srtl_if.sv =====
// Input item channel.
interface srtl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] begin_addr;
    logic [31:0] end_addr;
    logic [31:0] unwind_addr;
    logic [63:0] control_pc;

    modport source (output valid, output func, output begin_addr, output end_addr,
                    output unwind_addr, output control_pc, input ready);
    modport sink   (input valid, input func, input begin_addr, input end_addr,
                    input unwind_addr, input control_pc, output ready);
endinterface

// Result item channel.
interface srtl_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [31:0]               match_begin;
    logic [31:0]               match_end;
    logic [31:0]               match_unwind;
    logic [srtl_pkg::CNT_W-1:0] entry_count;

    modport source (output valid, output status, output match_begin, output match_end,
                    output match_unwind, output entry_count, input ready);
    modport sink   (input valid, input status, input match_begin, input match_end,
                    input match_unwind, input entry_count, output ready);
endinterface

// Configuration write channel for the module base register.
interface srtl_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_range_table_lookup_top.sv =====
// Sorted range table with lookup by program counter.
// Items arrive on i_in (valid/ready). func selects clear, insert or lookup
// (a func of 3 acts as a lookup). Each item gives exactly one result item on
// o_out (valid/ready). i_cfg writes the 64-bit module base and is always ready;
// write it only while no item is in flight.
// Items are worked one at a time. The result of an empty range, a counter below
// the base or an offset above 32 bits goes through the pending result register
// and the output register; a clear or an insert into a full table passes the
// table's done register before these. A lookup runs a binary search that reads
// one table word per cycle from the single-read-port entry memory.
// An insert runs the same search and then moves every entry above the new
// slot up by one, one entry per cycle.
// i_in.ready rises as soon as the previous result has moved into the output
// register. One result may wait on a stalled receiver while the next item is
// already being worked; further items then wait with i_in.ready low.
// Reset empties the table and clears the module base; the entry memory itself
// is not cleared, and no clearing pass is needed.
module sorted_range_table_lookup_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtl_in_if.sink    i_in,
    srtl_cfg_if.sink   i_cfg,
    srtl_out_if.source o_out
);
    import srtl_pkg::*;

    logic [63:0]  r_base;
    logic         r_busy;
    logic         r_res_valid;
    t_result      r_res;
    logic         r_out_valid;
    t_result      r_out;

    t_tbl_cmd     tbl_cmd;
    t_tbl_rsp     tbl_rsp;

    logic         accept;
    logic         out_free;
    logic [64:0]  offset;
    logic         is_lookup;
    logic         is_insert;
    logic         imm_hit;
    t_status      imm_status;

    srtl_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    // Module base register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg.valid) begin
            r_base <= i_cfg.data;
        end
    end

    // Decode the item and settle the cases that need no table access.
    always_comb begin
        accept     = i_in.valid && i_in.ready;
        out_free   = !r_out_valid || o_out.ready;
        offset     = {1'b0, i_in.control_pc} - {1'b0, r_base};
        is_lookup  = i_in.func[1];
        is_insert  = !i_in.func[1] && i_in.func[0];
        imm_hit    = 1'b0;
        imm_status = ST_DROPPED;
        if (is_lookup) begin
            if (offset[64]) begin
                imm_hit    = 1'b1;
                imm_status = ST_BELOW_BASE;
            end else if (|offset[63:32]) begin
                imm_hit    = 1'b1;
                imm_status = ST_TOO_LARGE;
            end
        end else if (is_insert) begin
            if (!(i_in.begin_addr < i_in.end_addr)) begin
                imm_hit    = 1'b1;
                imm_status = ST_DROPPED;
            end
        end

        tbl_cmd.start = accept && !imm_hit;
        if (is_lookup) begin
            tbl_cmd.op = OP_LOOKUP;
        end else if (is_insert) begin
            tbl_cmd.op = OP_INSERT;
        end else begin
            tbl_cmd.op = OP_CLEAR;
        end
        tbl_cmd.key               = is_lookup ? offset[31:0] : i_in.begin_addr;
        tbl_cmd.entry.start_addr  = i_in.begin_addr;
        tbl_cmd.entry.stop_addr   = i_in.end_addr;
        tbl_cmd.entry.unwind_addr = i_in.unwind_addr;
    end

    assign i_in.ready = !r_busy;

    // Pending result stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                if (imm_hit) begin
                    r_res_valid  <= 1'b1;
                    r_res.status <= imm_status;
                    r_res.match  <= '0;
                    r_res.count  <= tbl_rsp.res.count;
                end
            end
            if (tbl_rsp.done) begin
                r_res_valid <= 1'b1;
                r_res       <= tbl_rsp.res;
            end
            if (r_res_valid && out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
                r_res_valid <= 1'b0;
                r_busy      <= 1'b0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.match_begin  = r_out.match.start_addr;
    assign o_out.match_end    = r_out.match.stop_addr;
    assign o_out.match_unwind = r_out.match.unwind_addr;
    assign o_out.entry_count  = r_out.count;

endmodule

// ===== rtl/srtl_table.sv =====
module srtl_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srtl_pkg::t_tbl_cmd i_cmd,
    output srtl_pkg::t_tbl_rsp o_rsp
);
    import srtl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_SHIFT  = 3'b100
    } t_state;

    // Entry memory with one write port and one registered read port.
    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    t_state             r_state;
    t_op                r_op;
    logic [31:0]        r_key;
    t_entry             r_entry;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [IDX_W-1:0]   r_mid;
    logic               r_pend;
    logic               r_cand_v;
    t_entry             r_cand;
    logic [CNT_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_wptr;
    logic [CNT_W-1:0]   r_count;
    logic               r_done;
    t_status            r_status;
    t_entry             r_match;

    logic               search_hit;
    logic               go_left;
    logic               step_right;
    logic [CNT_W-1:0]   n_lo;
    logic [CNT_W-1:0]   n_hi;
    logic [CNT_W-1:0]   mid_wide;
    logic [IDX_W-1:0]   n_mid;
    logic               more;
    logic               n_cand_v;
    t_entry             n_cand;
    logic               found;
    logic               shift_more;
    logic [CNT_W-1:0]   rptr_dec;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // One search step per cycle: the word read last cycle narrows the bounds,
    // and the next midpoint is addressed at once.
    always_comb begin
        search_hit = (r_state == S_SEARCH) && r_pend;
        go_left    = r_key < r_rd_data.start_addr;
        step_right = search_hit && !go_left;
        n_lo       = r_lo;
        n_hi       = r_hi;
        if (search_hit) begin
            if (go_left) begin
                n_hi = {1'b0, r_mid};
            end else begin
                n_lo = {1'b0, r_mid} + CNT_W'(1);
            end
        end
        mid_wide = n_lo + ((n_hi - n_lo) >> 1);
        n_mid    = mid_wide[IDX_W-1:0];
        more     = n_lo < n_hi;
        // The last entry passed on the right is the candidate for a lookup.
        n_cand   = step_right ? r_rd_data : r_cand;
        n_cand_v = r_cand_v || step_right;
        found    = n_cand_v && (r_key < n_cand.stop_addr);
        shift_more = r_rptr > r_lo;
        rptr_dec   = r_rptr - CNT_W'(1);
    end

    // Memory port control for search and for the shift that opens a slot.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = n_mid;
        wr_en   = 1'b0;
        wr_addr = r_wptr[IDX_W-1:0];
        wr_data = r_rd_data;
        case (r_state)
            S_SEARCH: begin
                rd_en = more;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en = 1'b1;
                end
                if (shift_more) begin
                    rd_en   = 1'b1;
                    rd_addr = rptr_dec[IDX_W-1:0];
                end else if (!r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[IDX_W-1:0];
                    wr_data = r_entry;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_op     <= i_cmd.op;
                        r_key    <= i_cmd.key;
                        r_entry  <= i_cmd.entry;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_pend   <= 1'b0;
                        r_cand_v <= 1'b0;
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_status <= ST_CLEARED;
                                r_match  <= '0;
                                r_done   <= 1'b1;
                            end
                            OP_INSERT: begin
                                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                    r_status <= ST_FULL;
                                    r_match  <= '0;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: begin
                                r_state <= S_SEARCH;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    r_lo     <= n_lo;
                    r_hi     <= n_hi;
                    r_cand   <= n_cand;
                    r_cand_v <= n_cand_v;
                    if (more) begin
                        r_pend <= 1'b1;
                        r_mid  <= n_mid;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_op == OP_INSERT) begin
                            r_rptr  <= r_count;
                            r_state <= S_SHIFT;
                        end else begin
                            r_status <= found ? ST_FOUND : ST_NOT_FOUND;
                            r_match  <= found ? n_cand : '0;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_SHIFT: begin
                    // Move entries up by one from the top down to the slot.
                    if (shift_more) begin
                        r_pend <= 1'b1;
                        r_wptr <= r_rptr;
                        r_rptr <= rptr_dec;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_count  <= r_count + CNT_W'(1);
                            r_status <= ST_INSERTED;
                            r_match  <= '0;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done       = r_done;
    assign o_rsp.res.status = r_status;
    assign o_rsp.res.match  = r_match;
    assign o_rsp.res.count  = r_count;

endmodule
